// ===== hdl/eight_bit_cpu_core_assert.svh =====
// assertion macros shared by the checker files of the eight-bit cpu core
// depends on i_clk and i_rst_n being visible where a macro is used
`ifndef EIGHT_BIT_CPU_CORE_ASSERT_SVH
`define EIGHT_BIT_CPU_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define EBCPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define EBCPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ebcpu_pkg.sv =====
// shared types, opcodes, constants and address helpers of the eight-bit cpu core
// no dependencies
package ebcpu_pkg;

    localparam int MEM_DEPTH_DEF = 65536;
    localparam int REG_COUNT     = 16;
    localparam int REG_AW        = $clog2(REG_COUNT);

    localparam logic [15:0] IO_CMD_ADDR = 16'hFF01;
    localparam logic [15:0] IO_DAT_ADDR = 16'hFF02;

    // low nibble of the instruction byte
    typedef enum logic [3:0] {
        OP_NOP  = 4'd0,
        OP_LI   = 4'd1,
        OP_LA   = 4'd2,
        OP_HALT = 4'd3,
        OP_LB   = 4'd4,
        OP_WB   = 4'd5,
        OP_BZ   = 4'd6,
        OP_BC   = 4'd7,
        OP_ADD  = 4'd8,
        OP_SUB  = 4'd9,
        OP_MUL  = 4'd10,
        OP_AND  = 4'd11,
        OP_OR   = 4'd12,
        OP_NOR  = 4'd13,
        OP_SR   = 4'd14,
        OP_SL   = 4'd15
    } t_opcode;

    // full instruction bytes that are one byte long
    localparam logic [7:0] IR_NOP1  = 8'h00;
    localparam logic [7:0] IR_HALT1 = 8'h03;

    typedef struct packed {
        logic        req_type;
        logic [15:0] load_addr;
        logic [7:0]  load_data;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pc_next;
        logic        halted;
        logic        carry_flag;
        logic        io_strobe;
        logic [7:0]  io_command;
        logic [7:0]  io_data;
    } t_out_item;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // alu result toward the sequencer
    typedef struct packed {
        logic [7:0] value;
        logic       carry_upd;
        logic       carry;
    } t_alu_res;

    // address modulo memory depth; depth is at least 256 so nine restoring steps suffice
    function automatic logic [15:0] mem_wrap(input logic [15:0] addr, input int depth);
        logic [24:0] rem;
        logic [24:0] sub;
        rem = {9'd0, addr};
        sub = '0;
        if ((depth & (depth - 1)) == 0) begin
            return addr & 16'(depth - 1);
        end
        for (int j = 8; j >= 0; j--) begin
            sub = 25'(depth) << j;
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem[15:0];
    endfunction

endpackage

// ===== hdl/ebcpu_ram.sv =====
// generic single-clock ram: one write port, one read port, registered read data
// no dependencies
module ebcpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ebcpu_alu.sv =====
// register-to-register alu of the eight-bit cpu core
// depends on ebcpu_pkg
module ebcpu_alu import ebcpu_pkg::*; (
    input  t_opcode    i_op,
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    output t_alu_res   o_res
);

    logic [15:0] prod;
    logic [7:0]  shr;
    logic [7:0]  shl;
    logic [7:0]  back;
    logic        big;
    logic        lost;

    // product for mult, carry when it reaches 255
    assign prod = 16'(i_a) * 16'(i_b);

    // shifts of 8 or more clear the result; carry reports bits lost off the low end
    assign big  = (i_b[7:3] != 5'd0);
    assign shr  = i_a >> i_b[2:0];
    assign shl  = i_a << i_b[2:0];
    assign back = shr << i_b[2:0];
    assign lost = big ? (i_a != 8'd0) : (back != i_a);

    always_comb begin
        o_res = '0;
        case (i_op)
            OP_ADD: begin
                o_res.value = i_a + i_b;
            end
            OP_SUB: begin
                o_res.value     = i_a - i_b;
                o_res.carry_upd = 1'b1;
                o_res.carry     = (i_a <= i_b);
            end
            OP_MUL: begin
                o_res.value     = prod[7:0];
                o_res.carry_upd = 1'b1;
                o_res.carry     = (prod >= 16'd255);
            end
            OP_AND: begin
                o_res.value = i_a & i_b;
            end
            OP_OR: begin
                o_res.value = i_a | i_b;
            end
            OP_NOR: begin
                o_res.value = {7'd0, ((i_a | i_b) == 8'd0)};
            end
            OP_SR: begin
                o_res.value     = big ? 8'd0 : shr;
                o_res.carry_upd = 1'b1;
                o_res.carry     = lost;
            end
            OP_SL: begin
                o_res.value     = big ? 8'd0 : shl;
                o_res.carry_upd = 1'b1;
                o_res.carry     = lost;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

// ===== hdl/eight_bit_cpu_core.sv =====
// top level of the eight-bit cpu core: input buffer, sequencer, main memory,
// register file ram and result register; depends on ebcpu_pkg, ebcpu_ram, ebcpu_alu
//
//  channel   direction  handshake                          payload
//  request   in         i_in_valid / o_in_ready            i_in_item  (t_in_item)
//  result    out        o_out_valid / i_out_ready          o_out_item (t_out_item)
//
// a halted step does nothing; others fetch, ending there if one byte long or after the
// second byte for li, nop and halt, else reading operands and executing, plus a write
// back for lb and for la into other than r15; paced by the single read port of main
// memory and the register file ram read one operand per cycle. after reset a clearing
// pass zeroes main memory; requests are buffered but not started until it ends. one
// request waits in the input buffer while another runs or its result stalls.
module eight_bit_cpu_core import ebcpu_pkg::*; #(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [15:0] CMD_WRAP = mem_wrap(IO_CMD_ADDR, MEM_DEPTH);
    localparam logic [15:0] DAT_WRAP = mem_wrap(IO_DAT_ADDR, MEM_DEPTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_IR   = 10'b0000000010,
        ST_M    = 10'b0000000100,
        ST_A    = 10'b0000001000,
        ST_B    = 10'b0000010000,
        ST_C    = 10'b0000100000,
        ST_X    = 10'b0001000000,
        ST_LB   = 10'b0010000000,
        ST_W2   = 10'b0100000000,
        ST_DONE = 10'b1000000000
    } t_state;

    t_state             r_state, n_state;
    logic               r_in_vld, n_in_vld;
    t_in_item           r_in;
    logic [15:0]        r_pc, n_pc;
    logic               r_carry, n_carry;
    logic               r_halt, n_halt;
    logic               r_strobe, n_strobe;
    logic [7:0]         r_ir, n_ir;
    logic [7:0]         r_m, n_m;
    logic [7:0]         r_h, n_h;
    logic [7:0]         r_a, n_a;
    logic [7:0]         r_b, n_b;
    logic [7:0]         r_c, n_c;
    logic [7:0]         r_io_cmd, r_io_dat;
    logic               r_out_vld, n_out_vld;
    t_out_item          r_out;
    logic               out_load;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;
    logic [REG_COUNT-1:0] r_rf_vld;
    logic               r_rf_ok;

    // memory and register file port controls
    logic               mem_we;
    logic [15:0]        mem_waddr_full, mem_raddr_full;
    logic [15:0]        mem_waddr_wrap, mem_raddr_wrap;
    logic [AW-1:0]      mem_waddr;
    logic [7:0]         mem_wdata;
    logic [7:0]         mem_q;
    logic               rf_we;
    logic [REG_AW-1:0]  rf_waddr, rf_raddr;
    logic [7:0]         rf_wdata;
    logic [7:0]         rf_raw, rf_q;

    logic               pop;
    t_opcode            op;
    logic [REG_AW-1:0]  rd, rs;
    logic               pair;
    logic               need_h;
    logic [15:0]        tgt;
    t_alu_res           alu_res;

    assign op   = t_opcode'(r_ir[3:0]);
    assign rd   = r_ir[7:4];
    assign rs   = {1'b0, r_ir[7:5]};
    assign pair = r_ir[4];
    assign need_h = (op == OP_LA) ||
                    (!pair && (op == OP_LB || op == OP_WB || op == OP_BZ || op == OP_BC));
    assign tgt  = pair ? {r_b, r_a} : {r_h, r_m};

    assign o_in_ready = !r_in_vld;
    assign pop = (r_state == ST_IDLE) && r_in_vld && !r_clr_busy;

    // main memory
    assign mem_waddr_wrap = mem_wrap(mem_waddr_full, MEM_DEPTH);
    assign mem_raddr_wrap = mem_wrap(mem_raddr_full, MEM_DEPTH);
    assign mem_waddr = r_clr_busy ? r_clr_addr : mem_waddr_wrap[AW-1:0];

    ebcpu_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr_wrap[AW-1:0]),
        .o_rdata (mem_q)
    );

    // register file; register 0 is never written and never-written entries read zero
    ebcpu_ram #(
        .WIDTH (8),
        .DEPTH (REG_COUNT)
    ) u_rf (
        .i_clk   (i_clk),
        .i_we    (rf_we && (rf_waddr != '0)),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rf_raddr),
        .o_rdata (rf_raw)
    );

    assign rf_q = r_rf_ok ? rf_raw : 8'd0;

    ebcpu_alu u_alu (
        .i_op  (op),
        .i_a   (r_a),
        .i_b   (r_b),
        .o_res (alu_res)
    );

    // sequencer: fetch, operand reads, execute and write back
    always_comb begin
        n_state   = r_state;
        n_in_vld  = r_in_vld;
        n_pc      = r_pc;
        n_carry   = r_carry;
        n_halt    = r_halt;
        n_strobe  = r_strobe;
        n_ir      = r_ir;
        n_m       = r_m;
        n_h       = r_h;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr_full = r_in.load_addr;
        mem_wdata = r_in.load_data;
        mem_raddr_full = r_pc;
        rf_we     = 1'b0;
        rf_waddr  = rd;
        rf_wdata  = alu_res.value;
        rf_raddr  = r_m[3:0];

        case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    n_in_vld = 1'b0;
                    n_strobe = 1'b0;
                    if (r_in.req_type == REQ_LOAD) begin
                        mem_we  = 1'b1;
                        n_state = ST_DONE;
                    end else if (r_halt) begin
                        n_state = ST_DONE;
                    end else begin
                        n_pc    = r_pc + 16'd1;
                        n_state = ST_IR;
                    end
                end
            end
            ST_IR: begin
                n_ir = mem_q;
                if (mem_q == IR_NOP1) begin
                    n_state = ST_DONE;
                end else if (mem_q == IR_HALT1) begin
                    n_halt  = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_pc    = r_pc + 16'd1;
                    n_state = ST_M;
                end
            end
            ST_M: begin
                n_m      = mem_q;
                rf_raddr = mem_q[3:0];
                case (op)
                    OP_HALT: begin
                        n_halt  = 1'b1;
                        n_state = ST_DONE;
                    end
                    OP_NOP: begin
                        n_state = ST_DONE;
                    end
                    OP_LI: begin
                        rf_we    = 1'b1;
                        rf_wdata = mem_q;
                        n_state  = ST_DONE;
                    end
                    default: begin
                        if (need_h) begin
                            n_pc = r_pc + 16'd1;
                        end
                        n_state = ST_A;
                    end
                endcase
            end
            ST_A: begin
                if (need_h) begin
                    n_h = mem_q;
                end
                n_a      = rf_q;
                rf_raddr = r_m[7:4];
                n_state  = ST_B;
            end
            ST_B: begin
                n_b      = rf_q;
                rf_raddr = rs;
                n_state  = ST_C;
            end
            ST_C: begin
                n_c     = rf_q;
                n_state = ST_X;
            end
            ST_X: begin
                n_state = ST_DONE;
                case (op)
                    OP_LA: begin
                        rf_we    = 1'b1;
                        rf_wdata = r_m;
                        if (rd != 4'hF) begin
                            n_state = ST_W2;
                        end
                    end
                    OP_LB: begin
                        n_h            = tgt[15:8];
                        mem_raddr_full = tgt;
                        n_state        = ST_LB;
                    end
                    OP_WB: begin
                        n_h            = tgt[15:8];
                        mem_we         = 1'b1;
                        mem_waddr_full = tgt;
                        mem_wdata      = r_c;
                        n_strobe       = (tgt == IO_CMD_ADDR);
                    end
                    OP_BZ: begin
                        if (r_c == 8'd0) begin
                            n_h  = tgt[15:8];
                            n_pc = tgt;
                        end
                    end
                    OP_BC: begin
                        if (r_carry) begin
                            n_h  = tgt[15:8];
                            n_pc = tgt;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_NOR, OP_SR, OP_SL: begin
                        rf_we = 1'b1;
                        if (alu_res.carry_upd) begin
                            n_carry = alu_res.carry;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_LB: begin
                rf_we    = 1'b1;
                rf_waddr = rs;
                rf_wdata = mem_q;
                n_state  = ST_DONE;
            end
            ST_W2: begin
                rf_we    = 1'b1;
                rf_waddr = rd + 4'd1;
                rf_wdata = r_h;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // input buffer fills only when empty
        if (i_in_valid && o_in_ready) begin
            n_in_vld = 1'b1;
        end

        // the clearing pass owns the write port
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_wdata = 8'd0;
        end
    end

    // result register
    always_comb begin
        n_out_vld = r_out_vld;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (out_load) begin
            n_out_vld = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_vld   <= 1'b0;
            r_pc       <= 16'd0;
            r_carry    <= 1'b0;
            r_halt     <= 1'b0;
            r_strobe   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_rf_vld   <= '0;
            r_rf_ok    <= 1'b0;
            r_io_cmd   <= 8'd0;
            r_io_dat   <= 8'd0;
        end else begin
            r_state   <= n_state;
            r_in_vld  <= n_in_vld;
            r_pc      <= n_pc;
            r_carry   <= n_carry;
            r_halt    <= n_halt;
            r_strobe  <= n_strobe;
            r_out_vld <= n_out_vld;
            r_rf_ok   <= r_rf_vld[rf_raddr];
            if (rf_we && (rf_waddr != '0)) begin
                r_rf_vld[rf_waddr] <= 1'b1;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            // shadow copies of the two i/o bytes track every memory write
            if (mem_we && (mem_waddr == CMD_WRAP[AW-1:0])) begin
                r_io_cmd <= mem_wdata;
            end
            if (mem_we && (mem_waddr == DAT_WRAP[AW-1:0])) begin
                r_io_dat <= mem_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        r_ir <= n_ir;
        r_m  <= n_m;
        r_h  <= n_h;
        r_a  <= n_a;
        r_b  <= n_b;
        r_c  <= n_c;
        if (out_load) begin
            r_out.pc_next    <= r_pc;
            r_out.halted     <= r_halt;
            r_out.carry_flag <= r_carry;
            r_out.io_strobe  <= r_strobe;
            r_out.io_command <= r_io_cmd;
            r_out.io_data    <= r_io_dat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ===== hdl/ebcpu_checker.sv =====
// port-level checks of the eight-bit cpu core and their bind to the top level
// depends on ebcpu_pkg and eight_bit_cpu_core_assert.svh
`include "eight_bit_cpu_core_assert.svh"

module ebcpu_checker import ebcpu_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    logic out_stall;
    logic out_strobe;
    logic in_take;

    // handshake terms shared by the checks
    assign out_stall  = o_out_valid && !i_out_ready;
    assign out_strobe = o_out_valid && o_out_item.io_strobe;
    assign in_take    = i_in_valid && o_in_ready;

    // a stalled result stays offered
    `EBCPU_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid, "result dropped while stalled")

    // a stalled result keeps its payload
    `EBCPU_ASSERT_NEXT(a_out_stable, out_stall, $stable(o_out_item), "stalled result changed")

    // the request buffer holds one transaction
    `EBCPU_ASSERT_NEXT(a_in_one_deep, in_take, !o_in_ready, "buffer took a second transaction")

    // a strobe comes only from a write that left the core running
    `EBCPU_ASSERT_NOW(a_strobe_running, out_strobe, !o_out_item.halted, "strobe while halted")

endmodule

bind eight_bit_cpu_core ebcpu_checker u_ebcpu_checker (.*);
